/* hdl/sha224_stream_hasher_unit_defines.svh */
// Assertion macros shared by the checker.
`ifndef SHA224_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA224_STREAM_HASHER_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SHU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SHU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sha224_pkg.sv */
package sha224_pkg;

    // Entry in the queue between the byte packer and the compression engine.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        last;
    } t_item;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_PAD,
        t_ST_ROUND,
        t_ST_ADD,
        t_ST_EMIT
    } t_state;

    localparam logic [255:0] InitValue = {
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
    };

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* hdl/sha224_front.sv */
// Accepts message transactions, clamps the byte count and queues them.
module sha224_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_message_word,
    input  logic [2:0]           i_bytes_valid,
    input  logic                 i_last,
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output sha224_pkg::t_item    o_q_item
);
    sha224_pkg::t_item r_mem [2];
    logic              r_wr_ptr, r_rd_ptr;
    logic [1:0]        r_level;
    logic              push, pop;
    sha224_pkg::t_item n_item;

    assign o_ready   = (r_level != 2'd2);
    assign o_q_valid = (r_level != 2'd0);
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_item.word  = i_message_word;
        n_item.count = (i_bytes_valid > 3'd4) ? 3'd4 : i_bytes_valid;
        n_item.last  = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            r_level <= r_level + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* hdl/sha224_back.sv */
// Packs bytes into the block, runs the compression rounds, pads, and emits the digest.
module sha224_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  sha224_pkg::t_item    i_q_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_digest_word,
    output logic [2:0]           o_word_index,
    output logic                 o_last_word
);
    sha224_pkg::t_state r_state, n_state;
    logic [31:0] r_chain [8];
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [5:0]  r_fill;
    logic [63:0] r_len, r_len_snap;
    logic [5:0]  r_round;
    logic [2:0]  r_cnt;        // bytes of the current item still to place
    logic [31:0] r_data;
    logic        r_is_last;
    logic [3:0]  r_pad_idx;    // length bytes placed so far (0..8)
    logic        r_pad_mark;   // 0x80 already placed
    logic        r_fin;        // block in compression was the final one
    logic [2:0]  r_out_idx;

    logic [7:0]  pad_byte;
    logic        place, pad_place, take;
    logic [31:0] w_next, s0, s1, big0, big1, ch, maj, t1, t2;
    logic [7:0]  put_val;

    assign take    = (r_state == sha224_pkg::t_ST_IDLE) && i_q_valid && (r_cnt == 3'd0)
                     && !r_is_last;
    assign o_q_pop = take;

    // Byte to place during padding.
    always_comb begin
        if (!r_pad_mark) pad_byte = 8'h80;
        else if (r_fill != 6'd56 && r_pad_idx == 4'd0) pad_byte = 8'h00;
        else pad_byte = r_len_snap[63 - 8 * r_pad_idx[2:0] -: 8];
    end

    assign place     = (r_state == sha224_pkg::t_ST_IDLE) && (r_cnt != 3'd0);
    assign pad_place = (r_state == sha224_pkg::t_ST_PAD);
    assign put_val   = place ? r_data[31:24] : pad_byte;

    // Message schedule and round logic on a 16-word sliding window.
    always_comb begin
        s0     = sha224_pkg::rotr(r_w[1], 7) ^ sha224_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1     = sha224_pkg::rotr(r_w[14], 17) ^ sha224_pkg::rotr(r_w[14], 19)
                 ^ (r_w[14] >> 10);
        w_next = s1 + r_w[9] + s0 + r_w[0];
        big1   = sha224_pkg::rotr(r_v[4], 6) ^ sha224_pkg::rotr(r_v[4], 11)
                 ^ sha224_pkg::rotr(r_v[4], 25);
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1     = r_v[7] + big1 + ch + sha224_pkg::round_const(r_round) + r_w[0];
        big0   = sha224_pkg::rotr(r_v[0], 2) ^ sha224_pkg::rotr(r_v[0], 13)
                 ^ sha224_pkg::rotr(r_v[0], 22);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2     = big0 + maj;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha224_pkg::t_ST_IDLE: begin
                if (place && r_fill == 6'd63) n_state = sha224_pkg::t_ST_ROUND;
                else if (r_cnt == 3'd0 && r_is_last) n_state = sha224_pkg::t_ST_PAD;
            end
            sha224_pkg::t_ST_PAD: begin
                if (r_fill == 6'd63) n_state = sha224_pkg::t_ST_ROUND;
            end
            sha224_pkg::t_ST_ROUND: begin
                if (r_round == 6'd63) n_state = sha224_pkg::t_ST_ADD;
            end
            sha224_pkg::t_ST_ADD: begin
                // Bytes of the last item may still wait when the block filled mid-word.
                if (r_fin) n_state = sha224_pkg::t_ST_EMIT;
                else if (r_is_last && r_cnt == 3'd0) n_state = sha224_pkg::t_ST_PAD;
                else n_state = sha224_pkg::t_ST_IDLE;
            end
            sha224_pkg::t_ST_EMIT: begin
                if (i_ready && r_out_idx == 3'd6) n_state = sha224_pkg::t_ST_IDLE;
            end
            default: n_state = sha224_pkg::t_ST_IDLE;
        endcase
    end

    always_comb begin
        o_valid       = (r_state == sha224_pkg::t_ST_EMIT);
        o_digest_word = r_chain[r_out_idx];
        o_word_index  = r_out_idx;
        o_last_word   = (r_out_idx == 3'd6);
    end

    always_ff @(posedge i_clk) begin
        if (take) r_data <= i_q_item.word;
        else if (place) r_data <= {r_data[23:0], 8'h00};
        if (take && i_q_item.last) r_len_snap <= r_len + {58'd0, i_q_item.count, 3'd0};
        if (place || pad_place) begin
            r_w[r_fill[5:2]][31 - 8 * r_fill[1:0] -: 8] <= put_val;
        end
        if (r_state == sha224_pkg::t_ST_ROUND) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k + 1];
            r_w[15] <= w_next;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end else if (n_state == sha224_pkg::t_ST_ROUND) begin
            for (int k = 0; k < 8; k++) r_v[k] <= r_chain[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha224_pkg::t_ST_IDLE;
            r_fill     <= 6'd0;
            r_len      <= 64'd0;
            r_round    <= 6'd0;
            r_cnt      <= 3'd0;
            r_is_last  <= 1'b0;
            r_pad_idx  <= 4'd0;
            r_pad_mark <= 1'b0;
            r_fin      <= 1'b0;
            r_out_idx  <= 3'd0;
            for (int k = 0; k < 8; k++) r_chain[k] <= sha224_pkg::InitValue[255 - 32 * k -: 32];
        end else begin
            r_state <= n_state;
            if (take) begin
                r_cnt     <= i_q_item.count;
                r_is_last <= i_q_item.last;
                r_len     <= r_len + {58'd0, i_q_item.count, 3'd0};
            end else if (place) begin
                r_cnt <= r_cnt - 3'd1;
            end
            if (place || pad_place) begin
                r_fill <= r_fill + 6'd1;
                if (pad_place) begin
                    if (!r_pad_mark) r_pad_mark <= 1'b1;
                    else if (r_fill == 6'd56 || r_pad_idx != 4'd0) begin
                        r_pad_idx <= r_pad_idx + 4'd1;
                        if (r_fill == 6'd63) r_fin <= 1'b1;
                    end
                end
            end
            if (r_state == sha224_pkg::t_ST_ROUND) r_round <= r_round + 6'd1;
            if (r_state == sha224_pkg::t_ST_ADD) begin
                for (int k = 0; k < 8; k++) r_chain[k] <= r_chain[k] + r_v[k];
            end
            if (o_valid && i_ready) begin
                if (r_out_idx == 3'd6) begin
                    r_out_idx  <= 3'd0;
                    r_fill     <= 6'd0;
                    r_len      <= 64'd0;
                    r_is_last  <= 1'b0;
                    r_pad_idx  <= 4'd0;
                    r_pad_mark <= 1'b0;
                    r_fin      <= 1'b0;
                    for (int k = 0; k < 8; k++)
                        r_chain[k] <= sha224_pkg::InitValue[255 - 32 * k -: 32];
                end else begin
                    r_out_idx <= r_out_idx + 3'd1;
                end
            end
        end
    end
endmodule

/* hdl/sha224_stream_hasher_unit.sv */
// SHA-224 stream hasher.
// Input channel: i_valid/o_ready with i_message_word (first byte in bits 31:24),
// i_bytes_valid (0..4, larger values count as 4) and i_last. A transaction with
// i_last closes the message: padding and the length are appended and the digest
// follows on the output channel as seven transactions o_digest_word, word index
// 0..6, o_last_word on the seventh. The block then starts a fresh message.
// A two-entry queue decouples the input from the compression engine.
// Throughput: a word is popped from the queue once all bytes of the previous one are
// packed, and its valid bytes are then packed one per cycle; each full 64-byte block
// then runs 64 rounds (one round per cycle) and is folded into the chain.
// After a last transaction, padding places one byte per cycle (9 to 72 bytes)
// around one or two compressions, then the seven words go out at one per cycle
// while the receiver is ready. When the receiver stalls, the current word holds and
// the engine waits; the queue fills and o_ready then drops. Synchronous active-low
// reset restores the initial hash values and empties the queue.
module sha224_stream_hasher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_bytes_valid,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    logic              q_valid, q_pop;
    sha224_pkg::t_item q_item;

    sha224_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_message_word, .i_bytes_valid,
        .i_last, .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    sha224_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_item(q_item),
        .o_valid, .i_ready, .o_digest_word, .o_word_index, .o_last_word
    );
endmodule

/* hdl/sha224_checker.sv */
`include "sha224_stream_hasher_unit_defines.svh"

module sha224_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_word_index,
    input logic        o_last_word,
    input logic [31:0] o_digest_word
);
    `SHU_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, o_valid, o_last_word == (o_word_index == 3'd6), "last_word mismatch")
    `SHU_ASSERT_IMPL(a_idx_range, i_clk, i_rst_n, o_valid, o_word_index != 3'd7, "index out of range")
    `SHU_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, o_valid && i_ready && !o_last_word, o_valid && o_word_index == $past(o_word_index) + 3'd1, "digest words not consecutive")
    `SHU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_digest_word), "stalled word changed")
endmodule

bind sha224_stream_hasher_unit sha224_checker u_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_word_index, .o_last_word, .o_digest_word
);
